// ===== rtl/spc_pkg.sv =====
// Shared types, constants and the arctangent table for the polar to Cartesian scan block.
// No dependencies. Used by spc_ctrl, spc_datapath and scan_polar_to_cartesian.
package spc_pkg;

    // Widths of the ports and registers
    localparam int RANGE_W = 16;
    localparam int ANGLE_W = 16;
    localparam int OUT_W   = 17;
    localparam int BEAM_W  = 12;
    localparam int CFG_IDX_W = 2;

    // Beam counter wraps at the smaller of MAX_BEAMS and the 12-bit span
    localparam int MAX_BEAMS  = 4096;
    localparam int BEAM_LIMIT = (MAX_BEAMS < 4096) ? MAX_BEAMS : 4096;

    // CORDIC iteration count, capped by the table length
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int STEP_COUNT   = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(STEP_COUNT);
    localparam int ATAN_IDX_W   = 5;
    localparam int ATAN_W       = 22;

    // Datapath widths: vector needs 34 signed bits with CORDIC growth, one spare
    localparam int X_W    = 35;
    localparam int Z_W    = 26;
    localparam int PROD_W = 48;

    // Inverse CORDIC gain in Q32
    localparam logic [31:0] GAIN_Q32 = 32'd2608131497;
    localparam logic [16:0] OUT_LIMIT = 17'd65535;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ANGLE = 2'd0,
        CFG_ANGLE_STEP  = 2'd1,
        CFG_MIN_RANGE   = 2'd2,
        CFG_MAX_RANGE   = 2'd3
    } cfg_idx_t;

    // Controller state, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ITER = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic              accept;
        logic              load;
        logic              iterate;
        logic [STEP_W-1:0] step;
        logic              store;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic valid_pt;
    } status_t;

    // atan(2^-i) scaled to a half turn of 2^23
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 22'd2097152;
                5'd1:    v = 22'd1238021;
                5'd2:    v = 22'd654136;
                5'd3:    v = 22'd332050;
                5'd4:    v = 22'd166669;
                5'd5:    v = 22'd83416;
                5'd6:    v = 22'd41718;
                5'd7:    v = 22'd20860;
                5'd8:    v = 22'd10430;
                5'd9:    v = 22'd5215;
                5'd10:   v = 22'd2608;
                5'd11:   v = 22'd1304;
                5'd12:   v = 22'd652;
                5'd13:   v = 22'd326;
                5'd14:   v = 22'd163;
                5'd15:   v = 22'd81;
                5'd16:   v = 22'd41;
                5'd17:   v = 22'd20;
                5'd18:   v = 22'd10;
                5'd19:   v = 22'd5;
                5'd20:   v = 22'd3;
                5'd21:   v = 22'd1;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/spc_ctrl.sv =====
// Sequencer for the scan conversion: accept, gain multiply, CORDIC steps, result hand-off.
// Depends on spc_pkg.
module spc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    output logic              result_valid,
    input  logic              result_stall,
    input  spc_pkg::status_t  status,
    output spc_pkg::cmd_t     cmd
);

    spc_pkg::state_t             state_reg, state_next;
    logic [spc_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;
    logic                        last_step;

    assign out_free  = !out_valid_reg || !result_stall;
    assign last_step = (step_reg == spc_pkg::STEP_W'(spc_pkg::STEP_COUNT - 1));

    assign sample_stall = (state_reg != spc_pkg::S_IDLE);
    assign result_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd.accept     = 1'b0;
        cmd.load       = 1'b0;
        cmd.iterate    = 1'b0;
        cmd.step       = step_reg;
        cmd.store      = 1'b0;
        unique case (state_reg)
            spc_pkg::S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = spc_pkg::S_MUL;
                end
            end
            spc_pkg::S_MUL:
            begin
                cmd.load  = 1'b1;
                step_next = '0;
                // out-of-window samples skip the rotation
                state_next = status.valid_pt ? spc_pkg::S_ITER : spc_pkg::S_DONE;
            end
            spc_pkg::S_ITER:
            begin
                cmd.iterate = 1'b1;
                step_next   = step_reg + 1'b1;
                if (last_step)
                begin
                    state_next = spc_pkg::S_DONE;
                end
            end
            spc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    cmd.store  = 1'b1;
                    state_next = spc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spc_pkg::S_IDLE;
            end
        endcase
    end

    // Output request flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.store)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spc_pkg::S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Rotation ends after the last step
    a_iter_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spc_pkg::S_ITER) && last_step |=> (state_reg == spc_pkg::S_DONE))
        else $error("CORDIC did not finish after last step");

    // Out-of-window samples bypass the rotation
    a_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spc_pkg::S_MUL) && !status.valid_pt |=> (state_reg == spc_pkg::S_DONE))
        else $error("invalid sample entered rotation");

    // A stored result is presented next cycle
    a_store: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> out_valid_reg && (state_reg == spc_pkg::S_IDLE))
        else $error("stored result not presented");

    // Never overwrite a result that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !(out_valid_reg && result_stall))
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/spc_datapath.sv =====
// Config registers, beam counter, gain multiply, iterative CORDIC and output registers.
// Depends on spc_pkg; sequenced by spc_ctrl.
module spc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spc_pkg::cmd_t                 cmd,
    output spc_pkg::status_t              status,
    input  logic                          cfg_write,
    input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic [spc_pkg::RANGE_W-1:0]   range_mm,
    input  logic                          last_in_scan,
    output logic signed [spc_pkg::OUT_W-1:0] x_mm,
    output logic signed [spc_pkg::OUT_W-1:0] y_mm,
    output logic                          point_valid,
    output logic [spc_pkg::BEAM_W-1:0]    beam_number,
    output logic                          scan_end
);

    localparam int BW = spc_pkg::BEAM_W;
    localparam int XW = spc_pkg::X_W;
    localparam int ZW = spc_pkg::Z_W;
    localparam int PW = spc_pkg::PROD_W;
    localparam int RW = XW - 16;
    localparam logic [BW:0] BEAM_WRAP = (BW + 1)'(spc_pkg::BEAM_LIMIT);

    // Configuration
    logic [spc_pkg::ANGLE_W-1:0] start_angle_reg, angle_step_reg;
    logic [spc_pkg::RANGE_W-1:0] min_range_reg, max_range_reg;

    // Scan position
    logic [BW-1:0]               beam_cnt_reg;
    logic [spc_pkg::ANGLE_W-1:0] angle_ofs_reg;
    logic [BW:0]                 beam_inc;

    // Captured sample
    logic [spc_pkg::RANGE_W-1:0] range_reg;
    logic [spc_pkg::ANGLE_W-1:0] angle_reg;
    logic                        valid_reg, last_reg;
    logic [BW-1:0]               beam_reg;

    // CORDIC state
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;

    // Output registers
    logic signed [spc_pkg::OUT_W-1:0] x_out_reg, y_out_reg;
    logic                             valid_out_reg, end_out_reg;
    logic [BW-1:0]                    beam_out_reg;

    // Gain multiply and quadrant fold
    logic [PW-1:0]               prod;
    logic [31:0]                 x_start;
    logic                        fold;
    logic [spc_pkg::ANGLE_W-1:0] angle_fold;
    logic signed [XW-1:0]        x_init;
    logic signed [ZW-1:0]        z_init;

    // One CORDIC step
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] atan_val;

    // Rounding
    logic signed [RW-1:0] x_round, y_round;

    assign status.valid_pt = valid_reg;

    assign beam_inc = {1'b0, beam_cnt_reg} + 1'b1;

    // Configuration writes and scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
            min_range_reg   <= '0;
            max_range_reg   <= 16'hFFFF;
            beam_cnt_reg    <= '0;
            angle_ofs_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (spc_pkg::cfg_idx_t'(cfg_index))
                    spc_pkg::CFG_START_ANGLE: start_angle_reg <= cfg_data;
                    spc_pkg::CFG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                    spc_pkg::CFG_MIN_RANGE:   min_range_reg   <= cfg_data;
                    spc_pkg::CFG_MAX_RANGE:   max_range_reg   <= cfg_data;
                    default:                  start_angle_reg <= start_angle_reg;
                endcase
            end
            if (cmd.accept)
            begin
                if (last_in_scan)
                begin
                    beam_cnt_reg  <= '0;
                    angle_ofs_reg <= '0;
                end
                else
                begin
                    beam_cnt_reg  <= (beam_inc >= BEAM_WRAP) ? '0 : beam_inc[BW-1:0];
                    angle_ofs_reg <= angle_ofs_reg + angle_step_reg;
                end
            end
        end
    end

    // Capture the sample with its angle and window check
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            range_reg <= range_mm;
            last_reg  <= last_in_scan;
            beam_reg  <= beam_cnt_reg;
            angle_reg <= start_angle_reg + angle_ofs_reg;
            valid_reg <= (range_mm > min_range_reg) && (range_mm < max_range_reg);
        end
    end

    // Start vector: range times inverse gain, folded into the right half plane
    always_comb
    begin
        prod       = PW'(range_reg) * PW'(spc_pkg::GAIN_Q32);
        prod       = prod + PW'(32'h8000);
        x_start    = prod[47:16];
        fold       = angle_reg[15] ^ angle_reg[14];
        angle_fold = fold ? (angle_reg ^ 16'h8000) : angle_reg;
        x_init     = fold ? -$signed(XW'(x_start)) : $signed(XW'(x_start));
        z_init     = ZW'($signed({angle_fold, 8'h00}));
    end

    // Step with shift by the step index
    always_comb
    begin
        dx       = y_reg >>> cmd.step;
        dy       = x_reg >>> cmd.step;
        atan_val = $signed(ZW'(spc_pkg::atan_lut(spc_pkg::ATAN_IDX_W'(cmd.step))));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= x_init;
            y_reg <= '0;
            z_reg <= z_init;
        end
        else if (cmd.iterate)
        begin
            if (!z_reg[ZW-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_val;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_val;
            end
        end
    end

    // Round to millimeters and clamp to +-65535
    function automatic logic signed [spc_pkg::OUT_W-1:0] clamp_mm(input logic signed [RW-1:0] v);
        logic signed [spc_pkg::OUT_W-1:0] r;
        begin
            if (v > $signed(RW'(spc_pkg::OUT_LIMIT)))
            begin
                r = $signed(spc_pkg::OUT_LIMIT);
            end
            else if (v < -$signed(RW'(spc_pkg::OUT_LIMIT)))
            begin
                r = -$signed(spc_pkg::OUT_LIMIT);
            end
            else
            begin
                r = v[spc_pkg::OUT_W-1:0];
            end
            return r;
        end
    endfunction

    assign x_round = RW'((x_reg + XW'(32'sh8000)) >>> 16);
    assign y_round = RW'((y_reg + XW'(32'sh8000)) >>> 16);

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            x_out_reg     <= valid_reg ? clamp_mm(x_round) : '0;
            y_out_reg     <= valid_reg ? clamp_mm(y_round) : '0;
            valid_out_reg <= valid_reg;
            beam_out_reg  <= beam_reg;
            end_out_reg   <= last_reg;
        end
    end

    assign x_mm        = x_out_reg;
    assign y_mm        = y_out_reg;
    assign point_valid = valid_out_reg;
    assign beam_number = beam_out_reg;
    assign scan_end    = end_out_reg;

endmodule

// ===== rtl/scan_polar_to_cartesian.sv =====
// Lidar scan sample to Cartesian point converter, top level.
// Depends on spc_pkg, spc_ctrl and spc_datapath.
//
// Each range sample is accepted when sample_valid is high and sample_stall is low, and
// gives exactly one result request on the result channel. A sample is accepted, then
// goes through the gain multiply, CORDIC_STEPS steps on the single shift-add rotation
// unit, and rounding into the output register, which waits while a held result is
// stalled; only then is the next sample accepted. Samples outside the range window
// skip the rotation. A finished point sits in the output register while the
// next sample is being worked on. Configuration writes (cfg_ready is always high) are
// to be made only while the block is idle.
module scan_polar_to_cartesian (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic [spc_pkg::RANGE_W-1:0]       range_mm,
    input  logic                              last_in_scan,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [spc_pkg::OUT_W-1:0]  x_mm,
    output logic signed [spc_pkg::OUT_W-1:0]  y_mm,
    output logic                              point_valid,
    output logic [spc_pkg::BEAM_W-1:0]        beam_number,
    output logic                              scan_end,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                       cfg_data
);

    spc_pkg::cmd_t    cmd;
    spc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // Sequencer
    spc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Arithmetic and registers
    spc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .range_mm     (range_mm),
        .last_in_scan (last_in_scan),
        .x_mm         (x_mm),
        .y_mm         (y_mm),
        .point_valid  (point_valid),
        .beam_number  (beam_number),
        .scan_end     (scan_end)
    );

endmodule

// ===== tb/scan_polar_to_cartesian_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for scan_polar_to_cartesian: range samples and register writes
// go in, and each point coming out is compared with a bit-exact fixed-point CORDIC predictor.
// Depends on spc_pkg and the scan_polar_to_cartesian RTL.
module scan_polar_to_cartesian_test;

    localparam int     HALF_PERIOD     = 10;
    localparam int     RESET_CYCLES    = 6;
    localparam int     SETTLE_CYCLES   = 25;
    localparam int     WATCHDOG_LIMIT  = 3000;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     MAX_PRINTED     = 200;
    localparam int     LONG_SCAN       = 100;
    localparam longint INV_GAIN_Q32    = 64'sd2608131497;
    localparam longint SAT_LIMIT       = 64'sd65535;

    // One expected point
    typedef struct {
        logic signed [spc_pkg::OUT_W-1:0] x;
        logic signed [spc_pkg::OUT_W-1:0] y;
        logic                             point_valid;
        logic [spc_pkg::BEAM_W-1:0]       beam;
        logic                             scan_end;
    } scan_point_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             sample_valid;
    logic                             sample_stall;
    logic [spc_pkg::RANGE_W-1:0]      range_mm;
    logic                             last_in_scan;
    logic                             result_valid;
    logic                             result_stall;
    logic signed [spc_pkg::OUT_W-1:0] x_mm;
    logic signed [spc_pkg::OUT_W-1:0] y_mm;
    logic                             point_valid;
    logic [spc_pkg::BEAM_W-1:0]       beam_number;
    logic                             scan_end;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [spc_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [15:0]                      cfg_data;

    // Shadow of the registers and the scan state
    logic [15:0] start_angle_q;
    logic [15:0] angle_step_q;
    logic [15:0] min_range_q;
    logic [15:0] max_range_q;
    logic [15:0] angle_accum;
    int          beam_count;

    scan_point_t pending_points [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          hold_cycles = 0;
    bit          steady_flow = 1'b0;

    scan_polar_to_cartesian dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .range_mm     (range_mm),
        .last_in_scan (last_in_scan),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .x_mm         (x_mm),
        .y_mm         (y_mm),
        .point_valid  (point_valid),
        .beam_number  (beam_number),
        .scan_end     (scan_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // atan(2^-i), half turn = 2^23
    function automatic longint atan_q23(input int i);
        case (i)
            0:  return 2097152;
            1:  return 1238021;
            2:  return 654136;
            3:  return 332050;
            4:  return 166669;
            5:  return 83416;
            6:  return 41718;
            7:  return 20860;
            8:  return 10430;
            9:  return 5215;
            10: return 2608;
            11: return 1304;
            12: return 652;
            13: return 326;
            14: return 163;
            15: return 81;
            16: return 41;
            17: return 20;
            18: return 10;
            19: return 5;
            20: return 3;
            21: return 1;
            22: return 1;
            default: return 0;
        endcase
    endfunction

    // Drop 16 fraction bits with rounding, clamp to +-65535
    function automatic logic signed [spc_pkg::OUT_W-1:0] round_sat(input longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > SAT_LIMIT)
            r = SAT_LIMIT;
        if (r < -SAT_LIMIT)
            r = -SAT_LIMIT;
        return r[spc_pkg::OUT_W-1:0];
    endfunction

    // Expected point for one sample; advances the beam counter and angle offset
    function automatic scan_point_t predict_point(input logic [spc_pkg::RANGE_W-1:0] rng,
                                                  input logic last);
        scan_point_t pt;
        logic [15:0] ang;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        int          i;
        ang = start_angle_q + angle_accum;
        pt.x = '0;
        pt.y = '0;
        pt.point_valid = (rng > min_range_q) && (rng < max_range_q);
        pt.beam = beam_count[spc_pkg::BEAM_W-1:0];
        pt.scan_end = last;
        if (pt.point_valid)
        begin
            x = (longint'(rng) * INV_GAIN_Q32 + 64'sd32768) >>> 16;
            y = 0;
            // left half plane: fold by a half turn and start from the negated vector
            if (ang[15] != ang[14])
            begin
                ang[15] = ~ang[15];
                x = -x;
            end
            z = longint'($signed(ang)) * 256;
            for (i = 0; i < spc_pkg::STEP_COUNT; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_q23(i);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_q23(i);
                end
            end
            pt.x = round_sat(x);
            pt.y = round_sat(y);
        end
        if (last)
        begin
            beam_count = 0;
            angle_accum = '0;
        end
        else
        begin
            beam_count = (beam_count + 1 >= spc_pkg::BEAM_LIMIT) ? 0 : beam_count + 1;
            angle_accum = angle_accum + angle_step_q;
        end
        return pt;
    endfunction

    // Mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Range mostly inside the window, some on its edges, some anywhere
    function automatic logic [15:0] pick_range();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7 && int'(max_range_q) > int'(min_range_q) + 1)
            return 16'($urandom_range(int'(min_range_q) + 1, int'(max_range_q) - 1));
        case ($urandom_range(0, 3))
            0:       return min_range_q;
            1:       return max_range_q;
            2:       return 16'(int'(min_range_q) + 1);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    // One sample request; valid stays high afterwards so back-to-back requests don't glitch
    task automatic send_sample(input logic [spc_pkg::RANGE_W-1:0] rng, input logic last);
        int          gap;
        logic        taken;
        scan_point_t pt;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        range_mm <= rng;
        last_in_scan <= last;
        do
        begin
            @(negedge clk);
            taken = !sample_stall;
            @(posedge clk);
        end
        while (!taken);
        pt = predict_point(rng, last);
        pending_points.insert(pending_points.size(), pt);
    endtask

    // Stop sending, let every point come out, then give the pipeline time to settle
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input spc_pkg::cfg_idx_t idx, input logic [15:0] value);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
        case (idx)
            spc_pkg::CFG_START_ANGLE: start_angle_q = value;
            spc_pkg::CFG_ANGLE_STEP:  angle_step_q = value;
            spc_pkg::CFG_MIN_RANGE:   min_range_q = value;
            spc_pkg::CFG_MAX_RANGE:   max_range_q = value;
        endcase
    endtask

    // Full register set, only once the block has gone idle
    task automatic write_config(input logic [15:0] start, input logic [15:0] step,
                                input logic [15:0] lo, input logic [15:0] hi);
        wait_idle();
        write_reg(spc_pkg::CFG_START_ANGLE, start);
        write_reg(spc_pkg::CFG_ANGLE_STEP, step);
        write_reg(spc_pkg::CFG_MIN_RANGE, lo);
        write_reg(spc_pkg::CFG_MAX_RANGE, hi);
        cfg_valid <= 1'b0;
    endtask

    // Reset values: full window, angle zero; window edges are excluded
    task automatic test_reset_state();
        send_sample(16'd0, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'd65534, 1'b0);
        send_sample(16'd65535, 1'b1);
        wait_idle();
    endtask

    task automatic test_directed();
        // quarter-turn steps through all four quadrants at full scale
        write_config(16'h0000, 16'h4000, 16'd0, 16'd65535);
        repeat (4) send_sample(16'd65534, 1'b0);
        send_sample(16'd1, 1'b1);
        // angles on both sides of the half-plane fold
        write_config(16'h3FFF, 16'h0001, 16'd0, 16'd65535);
        send_sample(16'd50000, 1'b0);
        send_sample(16'd50000, 1'b0);
        send_sample(16'd50000, 1'b1);
        write_config(16'hBFFF, 16'h0001, 16'd0, 16'd65535);
        send_sample(16'd40000, 1'b0);
        send_sample(16'd40000, 1'b1);
        // window edges, most negative start and step
        write_config(16'h8000, 16'h8000, 16'd100, 16'd200);
        send_sample(16'd100, 1'b0);
        send_sample(16'd101, 1'b0);
        send_sample(16'd199, 1'b0);
        send_sample(16'd200, 1'b0);
        send_sample(16'd150, 1'b1);
        // inverted window: nothing is ever valid
        write_config(16'h7FFF, 16'h7FFF, 16'd65535, 16'd0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd65535, 1'b0);
        send_sample(16'd30000, 1'b1);
        // zero-width window, negative unit step
        write_config(16'h2000, 16'hFFFF, 16'd500, 16'd500);
        send_sample(16'd500, 1'b0);
        send_sample(16'd501, 1'b1);
    endtask

    // One long scan, mostly outside a narrow window
    task automatic test_long_scan();
        int i;
        write_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'd65000, 16'd65535);
        for (i = 0; i < LONG_SCAN; i++)
            send_sample(16'($urandom_range(0, 65535)), 1'b0);
        send_sample(16'($urandom_range(0, 65535)), 1'b1);
    endtask

    // Receiver holds off while samples keep coming, then the sender waits for a full drain
    task automatic test_backpressure();
        int i;
        write_config(16'h1000, 16'h0100, 16'd0, 16'd65535);
        hold_cycles = HOLD_OFF_CYCLES;
        for (i = 0; i < 12; i++)
            send_sample(pick_range(), i == 11);
        wait_idle();
        for (i = 0; i < 8; i++)
            send_sample(pick_range(), i == 7);
    endtask

    // Random scans of random length under several settings
    task automatic test_random_scans();
        int          phase;
        int          sent;
        int          len;
        int          k;
        logic [15:0] step;
        logic [15:0] lo;
        logic [15:0] hi;
        for (phase = 0; phase < 6; phase++)
        begin
            step = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 2) == 0)
                step = 16'($urandom_range(0, 600));
            lo = 16'($urandom_range(0, 3000));
            hi = 16'($urandom_range(20000, 65535));
            if (phase == 5)
            begin
                lo = 16'($urandom_range(0, 65535));
                hi = 16'($urandom_range(0, 65535));
            end
            case (phase)
                0:       write_config(16'h8000, 16'h7FFF, 16'd0, 16'd65535);
                1:       write_config(16'h7FFF, 16'h8000, 16'd1, 16'd65534);
                default: write_config(16'($urandom_range(0, 65535)), step, lo, hi);
            endcase
            steady_flow = (phase == 2);
            sent = 0;
            while (sent < 60)
            begin
                len = $urandom_range(1, 40);
                for (k = 0; k < len; k++)
                    send_sample(pick_range(), k == len - 1);
                sent += len;
            end
            steady_flow = 1'b0;
        end
    endtask

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin : result_side
        int n;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                result_stall <= 1'b0;
            end
            else if (!steady_flow && $urandom_range(0, 3) == 0)
            begin
                n = pick_gap() + 1;
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted point with the oldest expectation
    always @(negedge clk)
    begin : check_results
        scan_point_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_points.size() == 0)
                report_error($sformatf("point for beam %0d with no sample pending",
                                       beam_number));
            else
            begin
                want = pending_points.pop_front();
                if (x_mm !== want.x)
                    report_error($sformatf("beam %0d x_mm got %0d want %0d",
                                           want.beam, x_mm, want.x));
                if (y_mm !== want.y)
                    report_error($sformatf("beam %0d y_mm got %0d want %0d",
                                           want.beam, y_mm, want.y));
                if (point_valid !== want.point_valid)
                    report_error($sformatf("beam %0d point_valid got %b want %b",
                                           want.beam, point_valid, want.point_valid));
                if (beam_number !== want.beam)
                    report_error($sformatf("beam_number got %0d want %0d",
                                           beam_number, want.beam));
                if (scan_end !== want.scan_end)
                    report_error($sformatf("beam %0d scan_end got %b want %b",
                                           want.beam, scan_end, want.scan_end));
            end
        end
    end

    // Watchdog: cycles in a row with no request accepted on any channel
    always @(negedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        range_mm = '0;
        last_in_scan = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = spc_pkg::CFG_START_ANGLE;
        cfg_data = '0;
        start_angle_q = '0;
        angle_step_q = '0;
        min_range_q = '0;
        max_range_q = 16'hFFFF;
        angle_accum = '0;
        beam_count = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_long_scan();
        test_backpressure();
        test_random_scans();
        wait_idle();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spc_pkg.sv
rtl/spc_ctrl.sv
rtl/spc_datapath.sv
rtl/scan_polar_to_cartesian.sv
tb/scan_polar_to_cartesian_test.sv
